// ===== hdl/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants for the descending count sorter.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int unsigned MaxRecords = 1024;
  localparam int unsigned TagW       = 16;
  localparam int unsigned CountW     = 20;
  localparam int unsigned TopKW      = 7;
  localparam int unsigned RankW      = 6;
  localparam int unsigned ChainDepth = 64;
  localparam int unsigned TopKReset  = 10;

  localparam logic OpLoad = 1'b0;
  localparam logic OpSort = 1'b1;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [CountW-1:0] count;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic drain;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

endpackage

// ===== hdl/dcs_cell.sv =====
// ----------------------------------------------------------------------------
// dcs_cell
// One slot of the sorted insertion chain. Holds one record; on insert it
// keeps, takes the new record, or takes its upper neighbor's; on drain it
// takes its lower neighbor's record; on clear it empties.
// ----------------------------------------------------------------------------
module dcs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcs_pkg::cell_ctrl_t ctrl_i,
  input  dcs_pkg::rec_t      new_rec_i,
  input  dcs_pkg::rec_t      prev_rec_i,
  input  logic               prev_valid_i,
  input  logic               prev_take_i,
  input  dcs_pkg::rec_t      next_rec_i,
  input  logic               next_valid_i,
  output dcs_pkg::rec_t      rec_o,
  output logic               valid_o,
  output logic               take_o
);

  dcs_pkg::rec_t rec_q, rec_d;
  logic          valid_q, valid_d;

  // strict compare keeps equal counts in load order
  assign take_o = !valid_q || (new_rec_i.count > rec_q.count);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.drain) begin
      rec_d   = next_rec_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert) begin
      if (prev_take_i) begin
        rec_d   = prev_rec_i;
        valid_d = prev_valid_i;
      end else if (take_o) begin
        rec_d   = new_rec_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

// ===== hdl/descending_count_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// descending_count_sorter_unit
// Loads tagged counts and emits the top_k largest, stable, in rank order.
// ----------------------------------------------------------------------------
// Requests enter on start_i while busy_o is low; operation_i selects load or
// sort. A load gives no result: the record drops into a 64-cell insertion
// chain kept sorted by count, largest first, equal counts in load order.
// Loads beyond MAX_RECORDS are dropped and flagged.
// A sort raises busy_o and drains the chain head one cell per cycle: results
// appear one per cycle, n = min(records, top_k) of them, each taken from the
// head through the result registers once the state register enters StEmit;
// busy_o falls after the last. An empty table gives one result with
// empty_res_o set, the cycle after the request, without raising busy_o.
// Each result is valid for one cycle on result_valid_o; the receiver cannot
// stall. The sort clears the table and the dropped flag.
// cfg_we_i writes top_k (reset 10); 0 acts as 1, above 64 acts as 64.
// Reset empties the table and clears the dropped flag.
// ----------------------------------------------------------------------------
module descending_count_sorter_unit #(
  parameter int unsigned MAX_RECORDS = dcs_pkg::MaxRecords
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        operation_i,
  input  logic [dcs_pkg::TagW-1:0]    record_tag_i,
  input  logic [dcs_pkg::CountW-1:0]  record_count_i,
  input  logic                        cfg_we_i,
  input  logic [dcs_pkg::TopKW-1:0]   cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [dcs_pkg::TagW-1:0]    out_tag_o,
  output logic [dcs_pkg::CountW-1:0]  out_count_o,
  output logic [dcs_pkg::RankW-1:0]   out_rank_o,
  output logic                        empty_res_o,
  output logic                        dropped_o,
  output logic                        last_o
);

  localparam int unsigned HeldW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned Depth = dcs_pkg::ChainDepth;

  dcs_pkg::state_e state_q, state_d;

  logic [HeldW-1:0]          held_q, held_d;
  logic                      ovf_q, ovf_d;
  logic [dcs_pkg::TopKW-1:0] top_k_q;
  logic [dcs_pkg::TopKW-1:0] k_eff;
  logic [dcs_pkg::TopKW-1:0] n_q, n_d;
  logic [dcs_pkg::RankW-1:0] rank_q, rank_d;

  logic accept, is_load, is_sort, full, emit_last, emitting;
  dcs_pkg::cell_ctrl_t ctrl;
  dcs_pkg::rec_t       new_rec;

  dcs_pkg::rec_t cell_rec   [Depth];
  logic          cell_valid [Depth];
  logic          cell_take  [Depth];

  logic                       res_valid_q;
  logic [dcs_pkg::TagW-1:0]   res_tag_q;
  logic [dcs_pkg::CountW-1:0] res_count_q;
  logic [dcs_pkg::RankW-1:0]  res_rank_q;
  logic                       res_empty_q, res_drop_q, res_last_q;

  assign accept  = start_i && !busy_o;
  assign is_load = accept && (operation_i == dcs_pkg::OpLoad);
  assign is_sort = accept && (operation_i == dcs_pkg::OpSort);
  assign full    = (held_q == HeldW'(MAX_RECORDS));
  assign new_rec = '{tag: record_tag_i, count: record_count_i};

  always_comb begin
    if (top_k_q == '0) begin
      k_eff = dcs_pkg::TopKW'(1);
    end else if (top_k_q > dcs_pkg::TopKW'(dcs_pkg::ChainDepth)) begin
      k_eff = dcs_pkg::TopKW'(dcs_pkg::ChainDepth);
    end else begin
      k_eff = top_k_q;
    end
  end

  assign emit_last = ({1'b0, rank_q} + dcs_pkg::TopKW'(1)) == n_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dcs_pkg::StIdle: begin
        if (is_sort && held_q != '0) begin
          state_d = dcs_pkg::StEmit;
        end
      end
      dcs_pkg::StEmit: begin
        if (emit_last) begin
          state_d = dcs_pkg::StIdle;
        end
      end
      default: state_d = dcs_pkg::StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    busy_o   = 1'b0;
    emitting = 1'b0;
    case (state_q)
      dcs_pkg::StIdle: begin
        busy_o   = 1'b0;
        emitting = 1'b0;
      end
      dcs_pkg::StEmit: begin
        busy_o   = 1'b1;
        emitting = 1'b1;
      end
      default: begin
        busy_o   = 1'b0;
        emitting = 1'b0;
      end
    endcase
  end

  always_comb begin
    held_d      = held_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    rank_d      = rank_q;
    ctrl.insert = 1'b0;
    ctrl.drain  = 1'b0;
    ctrl.clear  = 1'b0;
    if (is_load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        held_d      = held_q + HeldW'(1);
        ctrl.insert = 1'b1;
      end
    end
    if (is_sort) begin
      rank_d = '0;
      if (held_q == '0) begin
        ovf_d = 1'b0;
      end else if (32'(held_q) < 32'(k_eff)) begin
        n_d = dcs_pkg::TopKW'(held_q);
      end else begin
        n_d = k_eff;
      end
    end
    if (emitting) begin
      ctrl.drain = 1'b1;
      rank_d     = rank_q + dcs_pkg::RankW'(1);
      if (emit_last) begin
        ctrl.clear = 1'b1;
        held_d     = '0;
        ovf_d      = 1'b0;
      end
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    dcs_pkg::rec_t prev_rec, next_rec;
    logic          prev_valid, prev_take, next_valid;

    if (i == 0) begin : g_head
      assign prev_rec   = new_rec;
      assign prev_valid = 1'b0;
      assign prev_take  = 1'b0;
    end else begin : g_mid
      assign prev_rec   = cell_rec[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_take  = cell_take[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_rec   = cell_rec[i];
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_rec   = cell_rec[i+1];
      assign next_valid = cell_valid[i+1];
    end

    dcs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_rec_i    (new_rec),
      .prev_rec_i   (prev_rec),
      .prev_valid_i (prev_valid),
      .prev_take_i  (prev_take),
      .next_rec_i   (next_rec),
      .next_valid_i (next_valid),
      .rec_o        (cell_rec[i]),
      .valid_o      (cell_valid[i]),
      .take_o       (cell_take[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcs_pkg::StIdle;
      held_q      <= '0;
      ovf_q       <= 1'b0;
      top_k_q     <= dcs_pkg::TopKW'(dcs_pkg::TopKReset);
      n_q         <= '0;
      rank_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      rank_q      <= rank_d;
      res_valid_q <= emitting || (is_sort && held_q == '0);
      if (cfg_we_i) begin
        top_k_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emitting) begin
      res_tag_q   <= cell_rec[0].tag;
      res_count_q <= cell_rec[0].count;
      res_rank_q  <= rank_q;
      res_empty_q <= 1'b0;
      res_drop_q  <= ovf_q;
      res_last_q  <= emit_last;
    end else if (is_sort) begin
      res_tag_q   <= '0;
      res_count_q <= '0;
      res_rank_q  <= '0;
      res_empty_q <= 1'b1;
      res_drop_q  <= ovf_q;
      res_last_q  <= 1'b1;
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_tag_o      = res_tag_q;
  assign out_count_o    = res_count_q;
  assign out_rank_o     = res_rank_q;
  assign empty_res_o    = res_empty_q;
  assign dropped_o      = res_drop_q;
  assign last_o         = res_last_q;

endmodule

// ===== bench/tb_descending_count_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_descending_count_sorter_unit
// Self-checking bench for the descending count sorter.
// ----------------------------------------------------------------------------
// Drives load and sort requests through the start/busy handshake and keeps
// its own copy of the record table. At each accepted sort it orders that
// copy, stable and largest first, and queues up to top_k ranks it expects.
// Every result strobe is compared field by field against the oldest queued
// rank. The run covers the empty table, equal counts, the top_k limits, a
// full table with refused loads, and random load bursts under sender idling.
// ----------------------------------------------------------------------------
module tb_descending_count_sorter_unit;

  localparam int unsigned TopKMax      = dcs_pkg::ChainDepth;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 80;

  typedef struct packed {
    logic [dcs_pkg::TagW-1:0]   tag;
    logic [dcs_pkg::CountW-1:0] count;
    logic [dcs_pkg::RankW-1:0]  rank;
    logic                       empty;
    logic                       dropped;
    logic                       last;
  } rank_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic                         operation_i;
  logic [dcs_pkg::TagW-1:0]     record_tag_i;
  logic [dcs_pkg::CountW-1:0]   record_count_i;
  logic                         cfg_we_i;
  logic [dcs_pkg::TopKW-1:0]    cfg_wdata_i;
  logic                         result_valid_o;
  logic [dcs_pkg::TagW-1:0]     out_tag_o;
  logic [dcs_pkg::CountW-1:0]   out_count_o;
  logic [dcs_pkg::RankW-1:0]    out_rank_o;
  logic                         empty_res_o;
  logic                         dropped_o;
  logic                         last_o;

  dcs_pkg::rec_t                loaded_records[dcs_pkg::MaxRecords];
  int unsigned                  loaded_total;
  logic                         load_refused;
  logic [dcs_pkg::TopKW-1:0]    top_k_shadow;
  rank_result_t                 pending_ranks[$];
  int unsigned                  mismatch_count;
  int unsigned                  cycle_count;
  int unsigned                  idle_pct;

  descending_count_sorter_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .record_tag_i   (record_tag_i),
    .record_count_i (record_count_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .out_tag_o      (out_tag_o),
    .out_count_o    (out_count_o),
    .out_rank_o     (out_rank_o),
    .empty_res_o    (empty_res_o),
    .dropped_o      (dropped_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("cycle %0d: mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // Table update for one accepted request; a sort queues its ranks.
  function automatic void predict_request(input logic op, input dcs_pkg::rec_t rec);
    dcs_pkg::rec_t ordered[$];
    dcs_pkg::rec_t cur;
    rank_result_t  res;
    int unsigned   k;
    int unsigned   n;
    int            j;
    if (op == dcs_pkg::OpLoad) begin
      if (loaded_total >= dcs_pkg::MaxRecords) begin
        load_refused = 1'b1;
      end else begin
        loaded_records[loaded_total] = rec;
        loaded_total++;
      end
      return;
    end
    if (loaded_total == 0) begin
      res         = '0;
      res.empty   = 1'b1;
      res.dropped = load_refused;
      res.last    = 1'b1;
      pending_ranks.push_back(res);
      load_refused = 1'b0;
      return;
    end
    // stable: a record goes behind every earlier one with an equal count
    for (int i = 0; i < loaded_total; i++) begin
      cur = loaded_records[i];
      j   = ordered.size();
      while (j > 0 && ordered[j-1].count < cur.count) j--;
      ordered.insert(j, cur);
    end
    k = top_k_shadow;
    if (k == 0) k = 1;
    if (k > TopKMax) k = TopKMax;
    n = (loaded_total < k) ? loaded_total : k;
    for (int i = 0; i < n; i++) begin
      res.tag     = ordered[i].tag;
      res.count   = ordered[i].count;
      res.rank    = dcs_pkg::RankW'(i);
      res.empty   = 1'b0;
      res.dropped = load_refused;
      res.last    = (i == n - 1);
      pending_ranks.push_back(res);
    end
    loaded_total = 0;
    load_refused = 1'b0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned g;
    g = 0;
    while (g < 16 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  function automatic logic [dcs_pkg::CountW-1:0] rand_count();
    case ($urandom_range(3))
      0:       return dcs_pkg::CountW'($urandom);
      1:       return dcs_pkg::CountW'($urandom_range(7));
      2:       return {dcs_pkg::CountW{1'b1}} - dcs_pkg::CountW'($urandom_range(3));
      default: return dcs_pkg::CountW'($urandom_range(1023));
    endcase
  endfunction

  // Holds start_i high after acceptance; the caller's next step decides.
  task automatic send_request(input logic op, input logic [dcs_pkg::TagW-1:0] tag,
                              input logic [dcs_pkg::CountW-1:0] count);
    int unsigned   gap;
    dcs_pkg::rec_t rec;
    gap = pick_gap();
    repeat (gap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    operation_i    <= op;
    record_tag_i   <= tag;
    record_count_i <= count;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    rec.tag   = tag;
    rec.count = count;
    predict_request(op, rec);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_top_k(input logic [dcs_pkg::TopKW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    top_k_shadow  = value;
  endtask

  task automatic test_empty_table();
    send_request(dcs_pkg::OpSort, dcs_pkg::TagW'($urandom), dcs_pkg::CountW'($urandom));
    drain_results();
  endtask

  task automatic test_reset_top_k();
    send_request(dcs_pkg::OpLoad, '0, '0);
    send_request(dcs_pkg::OpLoad, {dcs_pkg::TagW{1'b1}}, {dcs_pkg::CountW{1'b1}});
    send_request(dcs_pkg::OpLoad, 16'h5555, 20'hAAAAA);
    send_request(dcs_pkg::OpLoad, 16'hAAAA, 20'h55555);
    repeat (8) send_request(dcs_pkg::OpLoad, dcs_pkg::TagW'($urandom), rand_count());
    send_request(dcs_pkg::OpSort, dcs_pkg::TagW'($urandom), dcs_pkg::CountW'($urandom));
    drain_results();
  endtask

  task automatic test_equal_counts();
    write_top_k(7'd64);
    send_request(dcs_pkg::OpLoad, 16'h0001, 20'd5);
    send_request(dcs_pkg::OpLoad, 16'h0002, 20'd5);
    send_request(dcs_pkg::OpLoad, 16'h0003, 20'd9);
    send_request(dcs_pkg::OpLoad, 16'h0004, 20'd5);
    send_request(dcs_pkg::OpLoad, 16'h0005, 20'd9);
    send_request(dcs_pkg::OpLoad, 16'h0006, 20'd0);
    send_request(dcs_pkg::OpSort, '0, '0);
    drain_results();
  endtask

  task automatic test_top_k_limits();
    write_top_k(7'd0);
    repeat (3) send_request(dcs_pkg::OpLoad, dcs_pkg::TagW'($urandom), rand_count());
    send_request(dcs_pkg::OpSort, '0, '0);
    write_top_k(7'd65);
    repeat (70) send_request(dcs_pkg::OpLoad, dcs_pkg::TagW'($urandom), rand_count());
    send_request(dcs_pkg::OpSort, '0, '0);
    write_top_k(7'd127);
    repeat (3) send_request(dcs_pkg::OpLoad, dcs_pkg::TagW'($urandom), rand_count());
    send_request(dcs_pkg::OpSort, '0, '0);
    drain_results();
  endtask

  task automatic test_table_full();
    write_top_k(7'd64);
    repeat (dcs_pkg::MaxRecords + 3) begin
      send_request(dcs_pkg::OpLoad, dcs_pkg::TagW'($urandom), rand_count());
    end
    send_request(dcs_pkg::OpSort, '0, '0);
    send_request(dcs_pkg::OpSort, '0, '0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned items);
    int unsigned sent;
    int unsigned burst;
    sent     = 0;
    idle_pct = pct;
    while (sent < items) begin
      case ($urandom_range(9))
        0:       burst = 0;
        1:       burst = $urandom_range(20, 80);
        default: burst = $urandom_range(1, 12);
      endcase
      repeat (burst) send_request(dcs_pkg::OpLoad, dcs_pkg::TagW'($urandom), rand_count());
      send_request(dcs_pkg::OpSort, dcs_pkg::TagW'($urandom), dcs_pkg::CountW'($urandom));
      sent += burst + 1;
    end
    idle_pct = 0;
    drain_results();
  endtask

  always @(posedge clk_i) begin : check_results
    rank_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_ranks.size() == 0) begin
        report_mismatch($sformatf("unexpected result tag %0h count %0h rank %0d",
                                  out_tag_o, out_count_o, out_rank_o));
      end else begin
        want = pending_ranks.pop_front();
        check_field("out_tag", 32'(out_tag_o), 32'(want.tag));
        check_field("out_count", 32'(out_count_o), 32'(want.count));
        check_field("out_rank", 32'(out_rank_o), 32'(want.rank));
        check_field("empty_res", 32'(empty_res_o), 32'(want.empty));
        check_field("dropped", 32'(dropped_o), 32'(want.dropped));
        check_field("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    operation_i    = dcs_pkg::OpLoad;
    record_tag_i   = '0;
    record_count_i = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    loaded_total   = 0;
    load_refused   = 1'b0;
    top_k_shadow   = dcs_pkg::TopKW'(dcs_pkg::TopKReset);
    mismatch_count = 0;
    cycle_count    = 0;
    idle_pct       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_reset_top_k();
    test_equal_counts();
    test_top_k_limits();
    test_table_full();

    write_top_k(7'd127);
    test_random_traffic(0, 90);
    write_top_k(7'd5);
    test_random_traffic(65, 90);
    write_top_k(7'd64);
    test_random_traffic(0, 90);
    write_top_k(dcs_pkg::TopKW'($urandom_range(127)));
    test_random_traffic(12, 90);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_ranks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
